@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ design/sm3_pkg.sv @@
// ----------------------------------------------------------------------------
// SM3 package
// Constants, types and round functions shared by the SM3 engine modules.
// ----------------------------------------------------------------------------
package sm3_pkg;
	localparam logic [31:0] T_LOW  = 32'h79cc4519;
	localparam logic [31:0] T_HIGH = 32'h7a879d8a;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam logic [255:0] IV = {32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
		32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

	// kind of a queued word for the back end
	typedef enum logic [1:0] {
		WK_DATA = 2'd0,  // message word, no padding
		WK_FINAL = 2'd1  // already padded final word, then pad and finish
	} word_kind_t;

	typedef struct packed {
		logic [31:0] word;
		word_kind_t  kind;
		logic [2:0]  nbytes; // clipped to 0..4
		logic        full4;  // final word had four bytes: pad word follows
	} fq_entry_t;

	typedef enum logic [2:0] {
		BS_LOAD  = 3'd0,
		BS_ROUND = 3'd1,
		BS_FOLD  = 3'd2,
		BS_EMIT  = 3'd3
	} back_state_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] r);
		logic [63:0] d;
		d = {x, x} << r;
		return d[63:32];
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction
endpackage

@@ design/sm3_hash_engine_core.sv @@
// ----------------------------------------------------------------------------
// SM3 hash engine core
// Streaming SM3 (256-bit) hasher with a word queue ahead of the round unit.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one beat per 32-bit big-endian message word. tlast marks the
//   final beat, tuser gives its valid byte count (0..4, larger reads as 4,
//   left-aligned); other beats always carry four bytes.
//   m_* channel: after the final beat, eight digest beats, word_index in tuser,
//   tlast on the eighth.
// Flow: each 16-word block is loaded word by word as the queue supplies it,
//   then runs 64 rounds (one round per cycle in the shared round unit) and a
//   fold. Padding finishes in the block that holds the final word or adds
//   one more such block, then eight emit beats follow.
// A four-entry queue lets the sender run ahead while rounds execute.
// Reset: loads the SM3 initial value and clears the bit count and queue.
// Stall: digest beats hold while m_tready is low; input backs up via s_tready.
// ----------------------------------------------------------------------------
module sm3_hash_engine_core import sm3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // msg_word
	input  logic [2:0]  s_tuser,  // byte_count
	input  logic        s_tlast,  // last_item
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // digest_word
	output logic [2:0]  m_tuser,  // word_index
	output logic        m_tlast   // last_word
);
	logic q_valid, q_pop;
	fq_entry_t q_head;

	sm3_front u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
		.q_valid, .q_pop, .q_head
	);

	sm3_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_head,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
	);
endmodule

@@ design/sm3_front.sv @@
// ----------------------------------------------------------------------------
// SM3 front end
// Accepts message beats, masks and pads a final word of fewer than four bytes, feeds a short queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sm3_front import sm3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // msg_word
	input  logic [2:0]  s_tuser,  // byte_count
	input  logic        s_tlast,  // last_item
	output logic        q_valid,
	input  logic        q_pop,
	output fq_entry_t   q_head
);
	localparam int DEPTH = 4;
	fq_entry_t mem_q [DEPTH];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	fq_entry_t ent;
	logic [2:0] nb;
	logic [31:0] keep;
	logic push;

	always_comb begin
		nb = (s_tuser > 3'd4) ? 3'd4 : s_tuser;
		unique case (nb)
			3'd0: keep = 32'h0;
			3'd1: keep = 32'hff000000;
			3'd2: keep = 32'hffff0000;
			3'd3: keep = 32'hffffff00;
			default: keep = 32'hffffffff;
		endcase
		ent.nbytes = nb;
		ent.full4 = (nb == 3'd4);
		if (s_tlast) begin
			ent.kind = WK_FINAL;
			ent.word = (nb == 3'd4) ? s_tdata
				: ((s_tdata & keep) | ({24'h0, PAD_BYTE} << (5'd24 - {nb[1:0], 3'b000})));
		end else begin
			ent.kind = WK_DATA;
			ent.word = s_tdata;
		end
	end

	assign s_tready = (cnt_q != 3'(DEPTH));
	assign push = s_tvalid && s_tready;
	assign q_valid = (cnt_q != 3'd0);
	assign q_head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (q_pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, q_pop};
		end
	end

	`ASSERT_NEVER(a_no_pop_empty, clk, arst_n, q_pop && !q_valid)
	`ASSERT_IMPL(a_cnt_bound, clk, arst_n, cnt_q <= 3'(DEPTH))
	`ASSERT_IMPL(a_cnt_track, clk, arst_n,
		(push && !q_pop) |=> (cnt_q == $past(cnt_q) + 3'd1))
endmodule

@@ design/sm3_back.sv @@
// ----------------------------------------------------------------------------
// SM3 back end
// Fills the block buffer, pads, runs the 64 rounds one per cycle, emits the digest.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sm3_back import sm3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_pop,
	input  fq_entry_t   q_head,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // digest_word
	output logic [2:0]  m_tuser,  // word_index
	output logic        m_tlast   // last_word
);
	back_state_t st_q, st_d;
	logic [31:0] w_q [16];       // sliding message expansion window
	logic [3:0]  fill_q;
	logic [255:0] cv_q, v_q;
	logic [63:0] bits_q;
	logic [5:0]  rnd_q;
	logic        fin_q;          // padding in progress
	logic        padw_q;         // 0x80 word still to push
	logic        cnt_done_q;     // low length word pushed
	logic        lenlo_q;        // high length word pushed, low one next
	logic [2:0]  oidx_q;

	logic        load_en;
	logic [31:0] load_word;
	logic        wnew_en;
	logic [31:0] wnext;
	logic [31:0] a, b, c, d, e, f, g, h, a12, ss1, ss2, ff, gg, tt1, tt2, tj;

	// choose the word loaded this cycle; the length goes into slots 14 and 15
	always_comb begin
		load_en = 1'b0;
		load_word = '0;
		q_pop = 1'b0;
		if (st_q == BS_LOAD) begin
			if (fin_q) begin
				load_en = 1'b1;
				if (padw_q) load_word = {PAD_BYTE, 24'h0};
				else if (fill_q == 4'd14) load_word = bits_q[63:32];
				else if (lenlo_q) load_word = bits_q[31:0];
				else load_word = '0;
			end else if (q_valid) begin
				load_en = 1'b1;
				q_pop = 1'b1;
				load_word = q_head.word;
			end
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BS_LOAD: if (load_en && fill_q == 4'd15) st_d = BS_ROUND;
			BS_ROUND: if (rnd_q == 6'd63) st_d = BS_FOLD;
			BS_FOLD: st_d = (fin_q && cnt_done_q) ? BS_EMIT : BS_LOAD;
			BS_EMIT: if (m_tready && oidx_q == 3'd7) st_d = BS_LOAD;
			default: st_d = BS_LOAD;
		endcase
	end

	always_comb begin
		{a, b, c, d, e, f, g, h} = v_q;
		tj = (rnd_q < 6'd16) ? T_LOW : T_HIGH;
		a12 = rotl(a, 5'd12);
		ss1 = rotl(a12 + e + rotl(tj, rnd_q[4:0]), 5'd7);
		ss2 = ss1 ^ a12;
		if (rnd_q < 6'd16) begin
			ff = a ^ b ^ c;
			gg = e ^ f ^ g;
		end else begin
			ff = (a & b) | (a & c) | (b & c);
			gg = (e & f) | (~e & g);
		end
		tt1 = ff + d + ss2 + (w_q[0] ^ w_q[4]);
		tt2 = gg + h + ss1 + w_q[0];
		wnext = perm1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15)) ^ rotl(w_q[3], 5'd7) ^ w_q[10];
		wnew_en = (st_q == BS_ROUND);
	end

	always_ff @(posedge clk) begin
		if (load_en) w_q[fill_q] <= load_word;
		else if (wnew_en) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= wnext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BS_LOAD;
			fill_q <= '0;
			cv_q <= IV;
			v_q <= IV;
			bits_q <= '0;
			rnd_q <= '0;
			fin_q <= 1'b0;
			padw_q <= 1'b0;
			cnt_done_q <= 1'b0;
			lenlo_q <= 1'b0;
			oidx_q <= '0;
		end else begin
			st_q <= st_d;
			if (load_en) begin
				fill_q <= fill_q + 4'd1;
				if (fill_q == 4'd15) begin
					v_q <= cv_q;
					rnd_q <= '0;
				end
				if (fin_q) begin
					if (padw_q) padw_q <= 1'b0;
					else if (fill_q == 4'd14) lenlo_q <= 1'b1;
					else if (lenlo_q) begin
						lenlo_q <= 1'b0;
						cnt_done_q <= 1'b1;
					end
				end else if (q_head.kind == WK_FINAL) begin
					bits_q <= bits_q + {58'h0, q_head.nbytes, 3'b000};
					fin_q <= 1'b1;
					padw_q <= q_head.full4;
				end else begin
					bits_q <= bits_q + 64'd32;
				end
			end
			if (st_q == BS_ROUND) begin
				v_q <= {tt1, a, rotl(b, 5'd9), c, perm0(tt2), e, rotl(f, 5'd19), g};
				rnd_q <= rnd_q + 6'd1;
			end
			if (st_q == BS_FOLD) cv_q <= cv_q ^ v_q;
			if (st_q == BS_EMIT && m_tready) begin
				oidx_q <= oidx_q + 3'd1;
				if (oidx_q == 3'd7) begin
					cv_q <= IV;
					bits_q <= '0;
					fin_q <= 1'b0;
					cnt_done_q <= 1'b0;
				end
			end
		end
	end

	assign m_tvalid = (st_q == BS_EMIT);
	assign m_tdata = cv_q[255 - 32 * oidx_q -: 32];
	assign m_tuser = oidx_q;
	assign m_tlast = (oidx_q == 3'd7);

	`ASSERT_IMPL(a_round_len, clk, arst_n, (st_q == BS_ROUND) |-> (fill_q == 4'd0))
	`ASSERT_NEVER(a_pop_outside_load, clk, arst_n, q_pop && st_q != BS_LOAD)
	`ASSERT_IMPL(a_emit_hold, clk, arst_n,
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(oidx_q)))
endmodule
